/* rtl/dri_pkg.sv */
// ----------------------------------------------------------------------------
// dri_pkg
// Types and constants shared by the delimited record indexer modules.
// ----------------------------------------------------------------------------
package dri_pkg;

  localparam logic [7:0]  NL_BYTE       = 8'h0A;
  localparam logic [7:0]  DELIM_RESET   = 8'h25;
  localparam logic [31:0] MAX_LEN_RESET = 32'd4096;

  localparam logic [1:0] REG_DELIM    = 2'd0;
  localparam logic [1:0] REG_COMMENTS = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_COUNT  = 1'b1;

  localparam int unsigned FIFO_DEPTH = 3;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DELIM = 2'd1,
    PH_LINE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] offset;
    logic [31:0] number;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* rtl/dri_rslt_fifo.sv */
// ----------------------------------------------------------------------------
// dri_rslt_fifo
// Three-entry result queue that takes up to two results per cycle and
// hands out one per cycle from its head.
// ----------------------------------------------------------------------------
module dri_rslt_fifo (
  input  logic             clk,
  input  logic             rst,
  input  dri_pkg::push_t   push,
  input  logic             pop,
  output dri_pkg::result_t head,
  output logic [1:0]       count
);

  dri_pkg::result_t entries [dri_pkg::FIFO_DEPTH];
  dri_pkg::result_t entries_next [dri_pkg::FIFO_DEPTH];
  logic [1:0] count_next;
  logic [1:0] base;

  assign head = entries[0];
  assign base = count - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < dri_pkg::FIFO_DEPTH; i++) begin
      entries_next[i] = entries[i];
    end
    if (pop) begin
      for (int i = 0; i < dri_pkg::FIFO_DEPTH - 1; i++) begin
        entries_next[i] = entries[i + 1];
      end
    end
    for (int i = 0; i < dri_pkg::FIFO_DEPTH; i++) begin
      if ((push.cnt != 2'd0) && (2'(i) == base)) begin
        entries_next[i] = push.first;
      end
      if ((push.cnt == 2'd2) && (2'(i) == base + 2'd1)) begin
        entries_next[i] = push.second;
      end
    end
    count_next = base + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < dri_pkg::FIFO_DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

endmodule

/* rtl/delimited_record_indexer_core.sv */
// ----------------------------------------------------------------------------
// delimited_record_indexer_core
// Scans a text byte stream for records separated by delimiter lines and
// emits the start offset and number of each qualifying record, then the
// total count at end of input.
//
//   Channel  Dir   Signals                          Beat carries
//   s_*      in    tvalid tready tdata[7:0] tlast   data_byte, end_of_input
//   m_*      out   tvalid tready tdata tuser tlast  one result
//   cfg_*    in    valid ready index data           one register write
//
// One byte is taken per cycle if the queue has room; each beat is handled in
// the accept cycle and its results are queued in a three-entry result FIFO.
// An end-of-input beat that closes a record yields two results and holds
// s_tready low until the queue has room again; a stall on m_* fills it.
// Reset is synchronous and returns scan state and registers to defaults.
// ----------------------------------------------------------------------------
module delimited_record_indexer_core #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // record_offset[31:0], record_number[63:32]
  output logic [0:0]  m_tuser,   // result_kind[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]  delimiter_char;
  logic        comments_enable;
  logic [31:0] max_record_length;

  logic [OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_WIDTH-1:0] record_start, record_start_next;
  logic [31:0]             content_length, content_length_next;
  dri_pkg::phase_t         line_phase, line_phase_next;
  logic                    comment_line, comment_line_next;
  logic [31:0]             record_count, record_count_next;

  logic             accept;
  logic [63:0]      start_wide;
  logic [31:0]      close_len;
  logic [31:0]      count_inc;
  logic             rec_ok;
  dri_pkg::push_t   push;
  dri_pkg::result_t head;
  logic [1:0]       fifo_count;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, a} + {31'b0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign s_tready   = (fifo_count < 2'd2);
  assign accept     = s_tvalid && s_tready;
  assign start_wide = 64'(record_start);
  assign count_inc  = record_count + 32'd1;

  always_comb begin
    byte_offset_next    = byte_offset;
    record_start_next   = record_start;
    content_length_next = content_length;
    line_phase_next     = line_phase;
    comment_line_next   = comment_line;
    record_count_next   = record_count;
    close_len           = content_length;
    rec_ok              = 1'b0;
    push                = '0;

    if (accept && s_tlast) begin
      if (!comment_line && (line_phase == dri_pkg::PH_DELIM)) begin
        close_len = sat_add(content_length, 2'd1);
      end
      rec_ok = (close_len != 32'd0) && (close_len < max_record_length);
      if (rec_ok) begin
        push.cnt    = 2'd2;
        push.first  = '{kind: dri_pkg::KIND_RECORD, offset: start_wide[31:0],
                        number: count_inc, last: 1'b0};
        push.second = '{kind: dri_pkg::KIND_COUNT, offset: 32'd0,
                        number: count_inc, last: 1'b1};
      end else begin
        push.cnt    = 2'd1;
        push.first  = '{kind: dri_pkg::KIND_COUNT, offset: 32'd0,
                        number: record_count, last: 1'b1};
      end
      byte_offset_next    = '0;
      record_start_next   = '0;
      content_length_next = 32'd0;
      line_phase_next     = dri_pkg::PH_START;
      comment_line_next   = 1'b0;
      record_count_next   = 32'd0;
    end else if (accept) begin
      byte_offset_next = byte_offset + OFFSET_WIDTH'(1);
      if (comment_line) begin
        if (s_tdata == dri_pkg::NL_BYTE) begin
          comment_line_next = 1'b0;
          line_phase_next   = dri_pkg::PH_START;
        end
      end else begin
        case (line_phase)
          dri_pkg::PH_START: begin
            if (s_tdata == dri_pkg::NL_BYTE) begin
              content_length_next = sat_add(content_length, 2'd1);
            end else if (s_tdata == delimiter_char) begin
              line_phase_next = dri_pkg::PH_DELIM;
            end else begin
              content_length_next = sat_add(content_length, 2'd1);
              line_phase_next     = dri_pkg::PH_LINE;
            end
          end
          dri_pkg::PH_DELIM: begin
            if (s_tdata == dri_pkg::NL_BYTE) begin
              rec_ok = (content_length != 32'd0) && (content_length < max_record_length);
              if (rec_ok) begin
                record_count_next = count_inc;
                push.cnt   = 2'd1;
                push.first = '{kind: dri_pkg::KIND_RECORD, offset: start_wide[31:0],
                               number: count_inc, last: 1'b1};
              end
              record_start_next   = byte_offset_next;
              content_length_next = 32'd0;
              line_phase_next     = dri_pkg::PH_START;
            end else if (comments_enable && (s_tdata == delimiter_char)) begin
              comment_line_next = 1'b1;
              line_phase_next   = dri_pkg::PH_LINE;
            end else begin
              content_length_next = sat_add(content_length, 2'd2);
              line_phase_next     = dri_pkg::PH_LINE;
            end
          end
          default: begin
            content_length_next = sat_add(content_length, 2'd1);
            line_phase_next = (s_tdata == dri_pkg::NL_BYTE) ? dri_pkg::PH_START
                                                            : dri_pkg::PH_LINE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      record_start   <= '0;
      content_length <= 32'd0;
      line_phase     <= dri_pkg::PH_START;
      comment_line   <= 1'b0;
      record_count   <= 32'd0;
    end else begin
      byte_offset    <= byte_offset_next;
      record_start   <= record_start_next;
      content_length <= content_length_next;
      line_phase     <= line_phase_next;
      comment_line   <= comment_line_next;
      record_count   <= record_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char    <= dri_pkg::DELIM_RESET;
      comments_enable   <= 1'b0;
      max_record_length <= dri_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dri_pkg::REG_DELIM:    delimiter_char    <= cfg_data[7:0];
        dri_pkg::REG_COMMENTS: comments_enable   <= cfg_data[0];
        dri_pkg::REG_MAX_LEN:  max_record_length <= cfg_data;
        default: ;
      endcase
    end
  end

  dri_rslt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (m_tvalid && m_tready),
    .head  (head),
    .count (fifo_count)
  );

  assign m_tvalid = (fifo_count != 2'd0);
  assign m_tdata  = {head.number, head.offset};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (record_count == 32'd0) && (byte_offset == '0))
    else $error("scan state not cleared after end of input");

  a_count_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] == dri_pkg::KIND_COUNT)) |-> m_tlast)
    else $error("count result not marked as last");

  a_comment_phase: assert property (@(posedge clk) disable iff (rst)
    comment_line |-> (line_phase == dri_pkg::PH_LINE))
    else $error("comment line outside line body");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delimited record indexer. Byte streams built
// from text, comment, delimiter and noise lines are sent under several
// register settings while both handshakes idle at random. A scoreboard
// predicts every result beat and compares it field by field with the output.
// ----------------------------------------------------------------------------

class record_index_scoreboard;
  logic [7:0]  delim;
  logic        comments_on;
  logic [31:0] max_len;

  logic [31:0]     byte_pos;
  logic [31:0]     rec_start;
  logic [31:0]     content_len;
  logic [31:0]     rec_count;
  dri_pkg::phase_t phase;
  logic            comment_line;

  dri_pkg::result_t expected_q[$];
  int errors;
  int records_checked;
  int totals_checked;

  function new();
    delim = dri_pkg::DELIM_RESET;
    comments_on = 1'b0;
    max_len = dri_pkg::MAX_LEN_RESET;
    errors = 0;
    records_checked = 0;
    totals_checked = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    byte_pos = '0;
    rec_start = '0;
    content_len = '0;
    rec_count = '0;
    phase = dri_pkg::PH_START;
    comment_line = 1'b0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      dri_pkg::REG_DELIM:    delim = val[7:0];
      dri_pkg::REG_COMMENTS: comments_on = val[0];
      dri_pkg::REG_MAX_LEN:  max_len = val;
      default:               ;
    endcase
  endfunction

  function logic [31:0] sat_add(logic [31:0] a, logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void push_result(logic kind, logic [31:0] ofs, logic [31:0] num, logic last);
    dri_pkg::result_t r;
    r.kind = kind;
    r.offset = ofs;
    r.number = num;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function void close_record(logic [31:0] len);
    if (len != 0 && len < max_len) begin
      rec_count = rec_count + 1;
      push_result(dri_pkg::KIND_RECORD, rec_start, rec_count, 1'b0);
    end
  endfunction

  function void note_input(logic [7:0] b, logic eoi);
    logic [31:0] len;
    int queued;
    queued = expected_q.size();
    if (eoi) begin
      len = content_len;
      if (!comment_line && phase == dri_pkg::PH_DELIM) len = sat_add(len, 1);
      close_record(len);
      push_result(dri_pkg::KIND_COUNT, '0, rec_count, 1'b1);
      clear_scan();
      return;
    end
    byte_pos = byte_pos + 1;
    if (comment_line) begin
      if (b == dri_pkg::NL_BYTE) begin
        comment_line = 1'b0;
        phase = dri_pkg::PH_START;
      end
    end else if (phase == dri_pkg::PH_START) begin
      if (b == dri_pkg::NL_BYTE) begin
        content_len = sat_add(content_len, 1);
      end else if (b == delim) begin
        phase = dri_pkg::PH_DELIM;
      end else begin
        content_len = sat_add(content_len, 1);
        phase = dri_pkg::PH_LINE;
      end
    end else if (phase == dri_pkg::PH_DELIM) begin
      if (b == dri_pkg::NL_BYTE) begin
        close_record(content_len);
        rec_start = byte_pos;
        content_len = '0;
        phase = dri_pkg::PH_START;
      end else if (comments_on && b == delim) begin
        comment_line = 1'b1;
        phase = dri_pkg::PH_LINE;
      end else begin
        content_len = sat_add(content_len, 2);
        phase = dri_pkg::PH_LINE;
      end
    end else begin
      content_len = sat_add(content_len, 1);
      phase = (b == dri_pkg::NL_BYTE) ? dri_pkg::PH_START : dri_pkg::PH_LINE;
    end
    if (expected_q.size() > queued) expected_q[$].last = 1'b1;
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic kind, logic [31:0] ofs, logic [31:0] num, logic last);
    dri_pkg::result_t want_r;
    if (expected_q.size() == 0) begin
      $error("Unexpected result beat: kind %0d, offset %0d, number %0d", kind, ofs, num);
      errors++;
      return;
    end
    want_r = expected_q.pop_front();
    compare("result_kind", want_r.kind, kind);
    compare("record_offset", want_r.offset, ofs);
    compare("record_number", want_r.number, num);
    compare("last_of_run", want_r.last, last);
    if (want_r.kind == dri_pkg::KIND_COUNT) totals_checked++;
    else records_checked++;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  localparam real CLK_PERIOD    = 12.0;
  localparam int  LIMIT_CYCLES  = 400_000;
  localparam int  SETTLE_CYCLES = 8;
  localparam int  HOLD_CYCLES   = 200;
  localparam int  PHASE_BEATS   = 100;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  record_index_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int beats_sent;
  int settings_applied;

  delimited_record_indexer_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $error("Run did not finish within %0d cycles", LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: checks each accepted beat, then picks the next tready value.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_result(m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom_range(0, 255));
      s_tlast <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eoi;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, eoi);
    beats_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 8'(8'h61 + $urandom_range(0, 25));
    if (pick < 85) return 8'($urandom_range(0, 255));
    return sb.delim;
  endfunction

  task automatic send_line();
    int shape;
    int len;
    shape = $urandom_range(0, 9);
    len = $urandom_range(0, 6);
    if (shape <= 5) begin
      repeat (len) send_beat(text_byte(), 1'b0);
      send_beat(dri_pkg::NL_BYTE, 1'b0);
    end else if (shape <= 7) begin
      send_beat(sb.delim, 1'b0);
      send_beat(sb.delim, 1'b0);
      repeat (len) send_beat(text_byte(), 1'b0);
      send_beat(dri_pkg::NL_BYTE, 1'b0);
    end else if (shape == 8) begin
      send_beat(sb.delim, 1'b0);
      send_beat(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
      repeat (len) send_beat(text_byte(), 1'b0);
      send_beat(dri_pkg::NL_BYTE, 1'b0);
    end else begin
      repeat (len + 1) send_beat(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic send_record();
    repeat ($urandom_range(0, 3)) send_line();
    send_beat(sb.delim, 1'b0);
    if ($urandom_range(0, 9) != 0) send_beat(dri_pkg::NL_BYTE, 1'b0);
  endtask

  task automatic send_file();
    repeat ($urandom_range(1, 5)) send_record();
    if ($urandom_range(0, 1) == 1) send_line();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (sb.pending() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(input logic [7:0] delim, input logic comm,
                               input logic [31:0] max_len);
    write_reg(dri_pkg::REG_DELIM, {24'd0, delim});
    write_reg(dri_pkg::REG_COMMENTS, {31'd0, comm});
    write_reg(dri_pkg::REG_MAX_LEN, max_len);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int phase_start;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= dri_pkg::REG_DELIM;
    cfg_data <= '0;
    tx_idle_pct <= 18;
    rx_idle_pct <= 72;
    hold_req <= 0;
    beats_sent = 0;
    settings_applied = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset settings: separator lines, a doubled delimiter without comments,
    // extreme byte values, a lone delimiter at end, and restart after end.
    send_str("A\n%\n%%x\n");
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(dri_pkg::NL_BYTE, 1'b0);
    send_str("%");
    send_beat(8'h5A, 1'b1);
    send_str("%\n");
    send_beat(8'hA5, 1'b1);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: apply_setting(8'h25, 1'b1, 32'd4096);
        1: apply_setting(dri_pkg::NL_BYTE, 1'b1, 32'hFFFF_FFFF);
        2: apply_setting(8'h00, 1'b0, 32'd1);
        3: apply_setting(8'hFF, 1'b1, 32'd3);
        4: apply_setting(8'h23, 1'b1, 32'd12);
        5: apply_setting(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         $urandom_range(2, 20));
        6: apply_setting(8'h25, 1'b0, 32'd8);
        7: apply_setting(8'h80, 1'b1, 32'h7FFF_FFFF);
        default: apply_setting(8'($urandom_range(0, 255)), 1'b1, $urandom_range(5, 40));
      endcase
      case (p / 3)
        0: begin
          tx_idle_pct <= 18;
          rx_idle_pct <= 72;
        end
        1: begin
          tx_idle_pct <= 72;
          rx_idle_pct <= 18;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (p % 3 == 0) hold_req <= hold_req + 1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) send_file();
      wait_idle();
    end

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d stream beats under %0d register settings, with random and long stalls.",
             beats_sent, settings_applied);
    $display("Checked %0d record offsets and %0d end-of-input totals.",
             sb.records_checked, sb.totals_checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dri_pkg.sv
rtl/dri_rslt_fifo.sv
rtl/delimited_record_indexer_core.sv
tb/tb_top.sv
